### hdl/oaht_pkg.sv
// shared types and constants for the open addressing hash table
package oaht_pkg;

	localparam int CMD_W       = 2;
	localparam int KEY_PORT_W  = 64;
	localparam int HASH_W      = 32;
	localparam int VALUE_PORT_W = 64;
	localparam int STATUS_W    = 3;
	localparam int LIVE_W      = 9;
	localparam int MARK_W      = 2;

	localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_MISSING  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	localparam logic [LIVE_W-1:0] FILL_LIMIT_RESET = 9'd192;

	typedef struct packed {
		logic clear;
		logic load;
		logic eval;
	} dp_ctl_t;

	typedef struct packed {
		logic clear_last;
		logic nop;
		logic term;
	} dp_stat_t;

endpackage

### hdl/open_addressing_hash_table_core.sv
// top level of the open addressing hash table
// start to done: the request is loaded, fetched, then p slots are probed, p = 1 to 2^SLOT_BITS; unused code: no probe
// a new request is taken only once the previous one is done; the slot stores are walked one slot a cycle
// result beat is a one cycle done strobe; the receiver cannot stall it
// reset: busy while the slot marks are swept to empty
// reset: entry count zero, fill_limit 192; cfg writes are taken during the sweep
module open_addressing_hash_table_core #(
	parameter int SLOT_BITS   = 8,
	parameter int KEY_WIDTH   = 64,
	parameter int VALUE_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [oaht_pkg::CMD_W-1:0]          command,
	input  logic [oaht_pkg::KEY_PORT_W-1:0]     key,
	input  logic [oaht_pkg::HASH_W-1:0]         key_hash,
	input  logic [oaht_pkg::VALUE_PORT_W-1:0]   value_in,
	input  logic                                cfg_write,
	input  logic [oaht_pkg::LIVE_W-1:0]         cfg_data,
	output logic                                done,
	output logic                                found,
	output logic [oaht_pkg::VALUE_PORT_W-1:0]   value_out,
	output logic [oaht_pkg::STATUS_W-1:0]       status,
	output logic [oaht_pkg::LIVE_W-1:0]         live_count
);

	import oaht_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	oaht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	oaht_dp #(
		.SLOT_BITS   (SLOT_BITS),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.command    (command),
		.key        (key),
		.key_hash   (key_hash),
		.value_in   (value_in),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.found      (found),
		.value_out  (value_out),
		.status     (status),
		.live_count (live_count),
		.done       (done)
	);

endmodule

### hdl/oaht_ram.sv
// generic single write port ram with registered read
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/oaht_ctrl.sv
// controller state machine: clear pass, request accept, probe walk
module oaht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  oaht_pkg::dp_stat_t stat,
	output oaht_pkg::dp_ctl_t  ctl,
	output logic               busy
);

	import oaht_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_EVAL  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		ctl.clear = 1'b0;
		ctl.load  = 1'b0;
		ctl.eval  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					// the unused code answers at once without probing
					if (!stat.nop) begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				ctl.eval = 1'b1;
				if (stat.term) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_fetch_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_EVAL))
		else $error("fetch not followed by eval");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !busy)
		else $error("request loaded while busy");

	a_clear_exits_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.clear && stat.clear_last) |=> (state_q == ST_IDLE))
		else $error("clear pass did not end in idle");

endmodule

### hdl/oaht_dp.sv
// datapath: slot stores, probe registers, entry count and result registers
module oaht_dp #(
	parameter int SLOT_BITS   = 8,
	parameter int KEY_WIDTH   = 64,
	parameter int VALUE_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  oaht_pkg::dp_ctl_t                   ctl,
	output oaht_pkg::dp_stat_t                  stat,
	input  logic [oaht_pkg::CMD_W-1:0]          command,
	input  logic [oaht_pkg::KEY_PORT_W-1:0]     key,
	input  logic [oaht_pkg::HASH_W-1:0]         key_hash,
	input  logic [oaht_pkg::VALUE_PORT_W-1:0]   value_in,
	input  logic                                cfg_write,
	input  logic [oaht_pkg::LIVE_W-1:0]         cfg_data,
	output logic                                found,
	output logic [oaht_pkg::VALUE_PORT_W-1:0]   value_out,
	output logic [oaht_pkg::STATUS_W-1:0]       status,
	output logic [oaht_pkg::LIVE_W-1:0]         live_count,
	output logic                                done
);

	import oaht_pkg::*;

	localparam int SLOT_COUNT = 2 ** SLOT_BITS;
	localparam int CW = (SLOT_BITS + 1 > LIVE_W) ? SLOT_BITS + 1 : LIVE_W;
	localparam logic [CW-1:0] SLOT_COUNT_C = CW'(SLOT_COUNT);

	// request registers
	logic [CMD_W-1:0]       cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;

	// probe registers
	logic [SLOT_BITS-1:0] idx_q;
	logic [SLOT_BITS-1:0] n_q;
	logic [SLOT_BITS-1:0] tomb_q;
	logic                 have_tomb_q;
	logic [CW-1:0]        count_q;
	logic [LIVE_W-1:0]    fill_limit_q;

	// result registers
	logic                    found_q;
	logic [VALUE_WIDTH-1:0]  value_out_q;
	logic [STATUS_W-1:0]     status_q;
	logic [LIVE_W-1:0]       live_count_q;
	logic                    done_q;

	// store ports
	logic [SLOT_BITS-1:0]   raddr;
	logic [MARK_W-1:0]      mark_rd;
	logic [KEY_WIDTH-1:0]   key_rd;
	logic [VALUE_WIDTH-1:0] val_rd;
	logic                   mark_we, key_we, val_we;
	logic [SLOT_BITS-1:0]   mark_waddr, val_waddr;
	logic [MARK_W-1:0]      mark_wdata;

	// probe decision
	logic                 is_empty, is_live, is_tomb, match, last, term;
	logic [SLOT_BITS-1:0] spot;
	logic                 have_spot;
	logic                 fin, put_hit, insert, full, rem_hit, get_hit;
	logic [CW-1:0]        count_d;
	logic [STATUS_W-1:0]  status_d;

	assign is_empty = (mark_rd == MARK_EMPTY);
	assign is_live  = (mark_rd == MARK_LIVE);
	// any other mark behaves as a tombstone
	assign is_tomb  = !is_empty && !is_live;
	assign match    = is_live && (key_rd == key_q);
	assign last     = (n_q == {SLOT_BITS{1'b1}});
	assign term     = is_empty || match || last;

	// empty slot or exhausted walk: first tombstone wins, else this slot
	assign spot      = have_tomb_q ? tomb_q : idx_q;
	assign have_spot = is_empty || have_tomb_q || is_tomb;

	assign fin     = ctl.eval && term;
	assign full    = (count_q >= CW'(fill_limit_q)) || !have_spot;
	assign put_hit = fin && (cmd_q == CMD_PUT) && match;
	assign insert  = fin && (cmd_q == CMD_PUT) && !match && !full;
	assign rem_hit = fin && (cmd_q == CMD_REMOVE) && match;
	assign get_hit = fin && (cmd_q == CMD_GET) && match;

	always_comb begin
		count_d = count_q;
		if (insert) begin
			count_d = count_q + 1'b1;
		end else if (rem_hit && (count_q != '0)) begin
			count_d = count_q - 1'b1;
		end
	end

	always_comb begin
		case (cmd_q) inside
			CMD_PUT:    status_d = match ? STAT_UPDATED : (full ? STAT_FULL : STAT_INSERTED);
			CMD_GET,
			CMD_REMOVE: status_d = match ? STAT_DONE : STAT_MISSING;
			default:    status_d = STAT_MISSING;
		endcase
	end

	// next slot is addressed while the current one is checked
	assign raddr = ctl.eval ? idx_q + 1'b1 : idx_q;

	assign mark_we    = ctl.clear || insert || rem_hit;
	assign mark_waddr = ctl.clear ? idx_q : (insert ? spot : idx_q);
	assign mark_wdata = ctl.clear ? MARK_EMPTY : (insert ? MARK_LIVE : MARK_TOMB);
	assign key_we     = insert;
	assign val_we     = insert || put_hit;
	assign val_waddr  = insert ? spot : idx_q;

	oaht_ram #(.WIDTH(MARK_W), .DEPTH(SLOT_COUNT)) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.raddr (raddr),
		.rdata (mark_rd)
	);

	oaht_ram #(.WIDTH(KEY_WIDTH), .DEPTH(SLOT_COUNT)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (spot),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (key_rd)
	);

	oaht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SLOT_COUNT)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.raddr (raddr),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			n_q          <= '0;
			tomb_q       <= '0;
			have_tomb_q  <= 1'b0;
			count_q      <= '0;
			fill_limit_q <= FILL_LIMIT_RESET;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_write) begin
				fill_limit_q <= cfg_data;
			end
			if (ctl.clear) begin
				idx_q <= idx_q + 1'b1;
			end else if (ctl.load) begin
				idx_q       <= key_hash[SLOT_BITS-1:0];
				n_q         <= '0;
				have_tomb_q <= 1'b0;
				done_q      <= (command == CMD_NOP);
			end else if (ctl.eval) begin
				if (term) begin
					count_q <= count_d;
					done_q  <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
					n_q   <= n_q + 1'b1;
					if (is_tomb && !have_tomb_q) begin
						tomb_q      <= idx_q;
						have_tomb_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			key_q <= key[KEY_WIDTH-1:0];
			val_q <= value_in[VALUE_WIDTH-1:0];
			if (command == CMD_NOP) begin
				found_q      <= 1'b0;
				value_out_q  <= '0;
				status_q     <= STAT_MISSING;
				live_count_q <= count_q[LIVE_W-1:0];
			end
		end else if (fin) begin
			found_q      <= match;
			value_out_q  <= get_hit ? val_rd : '0;
			status_q     <= status_d;
			live_count_q <= count_d[LIVE_W-1:0];
		end
	end

	assign stat.clear_last = (idx_q == {SLOT_BITS{1'b1}});
	assign stat.nop        = (command == CMD_NOP);
	assign stat.term       = term;

	assign found      = found_q;
	assign value_out  = VALUE_PORT_W'(value_out_q);
	assign status     = status_q;
	assign live_count = live_count_q;
	assign done       = done_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SLOT_COUNT_C)
		else $error("entry count above slot count");

	a_no_insert_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> !key_we && !val_we)
		else $error("store written during clear pass");

	a_finish_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> done_q)
		else $error("finished probe gave no result beat");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!fin && !ctl.load |=> $stable(count_q))
		else $error("entry count moved outside a finish");

endmodule
